/* rtl/pxe_pkg.sv */
// ----------------------------------------------------------------------------
// pxe_pkg
// shared types, register codes and helper functions of the pixel expander
// ----------------------------------------------------------------------------
package pxe_pkg;

  localparam int MaxWidth         = 4096;
  localparam int MaxBytesPerPixel = 4;
  localparam int WidthLim         = (MaxWidth < 4096) ? MaxWidth : 4096;
  localparam int BppLim           = (MaxBytesPerPixel < 4) ? MaxBytesPerPixel : 4;
  localparam int PaletteEntries   = 256;
  localparam int QueueDepth       = 4;

  // legal index widths
  localparam logic [3:0] BpiOne   = 4'd1;
  localparam logic [3:0] BpiFour  = 4'd4;
  localparam logic [3:0] BpiEight = 4'd8;

  typedef enum logic [2:0] {
    CfgBitsPerIndex = 3'd0,
    CfgBytesPerPixel = 3'd1,
    CfgImageWidth = 3'd2,
    CfgImageHeight = 3'd3,
    CfgFlipVertical = 3'd4,
    CfgSourceAlignLog2 = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpPixel = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        last_of_byte;
    logic        end_of_image;
  } out_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [15:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  bits_per_index;
    logic [2:0]  bytes_per_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        flip_vertical;
    logic [2:0]  source_alignment_log2;
  } cfg_regs_t;

  // one queued job: a palette load or one image byte with its pixel span
  typedef struct packed {
    op_e         op;
    logic [7:0]  entry_index;
    logic [31:0] data;       // colour for a load, byte in the low bits otherwise
    logic [11:0] start_col;
    logic [3:0]  count;      // pixels to emit, 1 to 8
    logic [11:0] row;        // output row, already mirrored
    logic        last_row;
  } job_t;

  function automatic logic [12:0] eff_width(input cfg_regs_t c);
    logic [12:0] w;
    w = c.image_width;
    if (w == 13'd0) w = 13'd1;
    if (w > 13'(WidthLim)) w = 13'(WidthLim);
    return w;
  endfunction

  function automatic logic [12:0] eff_height(input cfg_regs_t c);
    logic [12:0] h;
    h = c.image_height;
    if (h == 13'd0) h = 13'd1;
    if (h > 13'd4096) h = 13'd4096;
    return h;
  endfunction

  function automatic logic [31:0] color_mask(input cfg_regs_t c);
    logic [2:0] b;
    b = c.bytes_per_pixel;
    if (b == 3'd0) b = 3'd1;
    if (b > 3'(BppLim)) b = 3'(BppLim);
    case (b)
      3'd1:    return 32'h0000_00FF;
      3'd2:    return 32'h0000_FFFF;
      3'd3:    return 32'h00FF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

/* rtl/pxe_chan_if.sv */
// ----------------------------------------------------------------------------
// pxe_chan_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface pxe_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pxe_front.sv */
// ----------------------------------------------------------------------------
// pxe_front
// accepts words, tracks column/row/line position and queues jobs
// ----------------------------------------------------------------------------
module pxe_front
  import pxe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_t       in_data_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output job_t      q_job_o
);

  logic [12:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [12:0] lbc_q, lbc_d;

  logic [12:0] width, height, hm1, data_bytes, rem, lbc_inc, row_inc;
  logic [13:0] line_len;
  logic [4:0]  amask;
  logic [2:0]  align;
  logic [3:0]  per_byte, n;
  logic        bits_ok, in_data, col_ok, end_line, accept, byte_fire;

  always_comb begin
    width  = eff_width(cfg_i);
    height = eff_height(cfg_i);
    hm1    = height - 13'd1;
    align  = (cfg_i.source_alignment_log2 > 3'd4) ? 3'd4 : cfg_i.source_alignment_log2;
    amask  = (5'd1 << align) - 5'd1;
    bits_ok = 1'b1;
    case (cfg_i.bits_per_index)
      BpiEight: begin
        data_bytes = width;
        per_byte   = 4'd1;
      end
      BpiFour: begin
        data_bytes = 13'((14'(width) + 14'd1) >> 1);
        per_byte   = 4'd2;
      end
      BpiOne: begin
        data_bytes = 13'((14'(width) + 14'd7) >> 3);
        per_byte   = 4'd8;
      end
      default: begin
        data_bytes = width;
        per_byte   = 4'd1;
        bits_ok    = 1'b0;
      end
    endcase
    line_len = (14'(data_bytes) + 14'(amask)) & ~14'(amask);
    in_data  = lbc_q < data_bytes;
    col_ok   = col_q < width;
    rem      = width - col_q;
    if (in_data && col_ok) begin
      n = (13'(per_byte) < rem) ? per_byte : rem[3:0];
    end else begin
      n = 4'd0;
    end
    lbc_inc  = lbc_q + 13'd1;
    end_line = 14'(lbc_inc) >= line_len;
    row_inc  = 13'(row_q) + 13'd1;
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign byte_fire  = accept && (op_e'(in_data_i.operation) == OpPixel) && bits_ok;
  assign q_push_o   = accept && ((op_e'(in_data_i.operation) == OpLoad) ||
                                 (bits_ok && n != 4'd0));

  always_comb begin
    q_job_o.op          = op_e'(in_data_i.operation);
    q_job_o.entry_index = in_data_i.entry_index;
    q_job_o.data        = (op_e'(in_data_i.operation) == OpLoad) ? in_data_i.entry_color
                                                                 : 32'(in_data_i.data_byte);
    q_job_o.start_col   = col_q[11:0];
    q_job_o.count       = n;
    q_job_o.row         = cfg_i.flip_vertical ? 12'(hm1 - 13'(row_q)) : row_q;
    q_job_o.last_row    = 13'(row_q) == hm1;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    lbc_d = lbc_q;
    if (byte_fire) begin
      if (end_line) begin
        lbc_d = 13'd0;
        col_d = 13'd0;
        row_d = (row_inc >= height) ? 12'd0 : row_inc[11:0];
      end else begin
        lbc_d = lbc_inc;
        col_d = col_q + 13'(n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      lbc_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      lbc_q <= lbc_d;
    end
  end

endmodule

/* rtl/pxe_job_fifo.sv */
// ----------------------------------------------------------------------------
// pxe_job_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module pxe_job_fifo
  import pxe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ptr_next(wptr_q);
      if (pop_i) rptr_q <= ptr_next(rptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/pxe_back.sv */
// ----------------------------------------------------------------------------
// pxe_back
// runs queued jobs: palette writes, and one palette lookup per pixel
// ----------------------------------------------------------------------------
module pxe_back
  import pxe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PaletteEntries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_t      out_data_o
);

  localparam int AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [31:0] pal_mem [PALETTE_ENTRIES];

  logic [2:0]  k_q;
  logic        out_vld_q;
  logic [31:0] rdata_q;
  logic [11:0] col_q, row_q;
  logic        last_q, eoi_q, zero_q;

  logic [7:0]  idx;
  logic [11:0] col;
  logic [12:0] wm1;
  logic        adv, wr, rd, last_px;

  assign adv     = !out_vld_q || out_ready_i;
  assign wr      = job_valid_i && (job_i.op == OpLoad) &&
                   (9'(job_i.entry_index) < 9'(PALETTE_ENTRIES));
  assign rd      = job_valid_i && (job_i.op == OpPixel) && adv;
  assign last_px = {1'b0, k_q} == (job_i.count - 4'd1);
  assign wm1     = eff_width(cfg_i) - 13'd1;
  assign col     = job_i.start_col + 12'(k_q);

  assign job_pop_o = job_valid_i && ((job_i.op == OpLoad) || (rd && last_px));

  // pick the k-th index of the byte, most significant first
  always_comb begin
    case (cfg_i.bits_per_index)
      BpiOne:  idx = {7'd0, job_i.data[3'd7 - k_q]};
      BpiFour: idx = k_q[0] ? {4'd0, job_i.data[3:0]} : {4'd0, job_i.data[7:4]};
      default: idx = job_i.data[7:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr) pal_mem[job_i.entry_index[AddrW-1:0]] <= job_i.data;
    if (rd) rdata_q <= pal_mem[idx[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rd) begin
      col_q  <= col;
      row_q  <= job_i.row;
      last_q <= last_px;
      eoi_q  <= job_i.last_row && (13'(col) == wm1);
      zero_q <= 9'(idx) >= 9'(PALETTE_ENTRIES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (rd) begin
        k_q <= last_px ? 3'd0 : k_q + 3'd1;
      end
      if (rd) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o             = out_vld_q;
  assign out_data_o.pixel_color  = zero_q ? 32'd0 : (rdata_q & color_mask(cfg_i));
  assign out_data_o.pixel_column = col_q;
  assign out_data_o.pixel_row    = row_q;
  assign out_data_o.last_of_byte = last_q;
  assign out_data_o.end_of_image = eoi_q;

endmodule

/* rtl/palette_index_pixel_expander.sv */
// ----------------------------------------------------------------------------
// palette_index_pixel_expander
// expands packed 1, 4 or 8 bit palette indices into coloured pixels
// ----------------------------------------------------------------------------
// Load words write palette entries; image words carry one source byte that
// yields 8, 2 or 1 pixels, most significant index first, each tagged with
// its column, its (optionally mirrored) row, a last-of-byte flag and an
// end-of-image flag. Padding bytes up to the 2^n source line alignment and
// pixels past the row width are consumed silently. The front end takes one
// input word per cycle whenever the four-entry job queue has room; the back
// end emits one pixel per cycle while the output is not stalled, bound by
// the single palette read port, so an image byte holds it for one lookup
// per pixel that it yields. No clearing pass follows reset; palette entries
// read before being loaded return unspecified colours. Configuration writes
// are taken every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module palette_index_pixel_expander
  import pxe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PaletteEntries
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pxe_chan_if.sink   in_i,
  pxe_chan_if.source out_o,
  pxe_chan_if.sink   cfg_i
);

  // configuration registers
  cfg_regs_t cfg_q;

  // queue between front and back
  logic q_push, q_full, q_pop, q_valid;
  job_t q_in, q_head;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits_per_index        <= BpiEight;
      cfg_q.bytes_per_pixel       <= 3'd3;
      cfg_q.image_width           <= 13'd1;
      cfg_q.image_height          <= 13'd1;
      cfg_q.flip_vertical         <= 1'b0;
      cfg_q.source_alignment_log2 <= 3'd0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.data.reg_index))
        CfgBitsPerIndex:    cfg_q.bits_per_index        <= cfg_i.data.wdata[3:0];
        CfgBytesPerPixel:   cfg_q.bytes_per_pixel       <= cfg_i.data.wdata[2:0];
        CfgImageWidth:      cfg_q.image_width           <= cfg_i.data.wdata[12:0];
        CfgImageHeight:     cfg_q.image_height          <= cfg_i.data.wdata[12:0];
        CfgFlipVertical:    cfg_q.flip_vertical         <= cfg_i.data.wdata[0];
        CfgSourceAlignLog2: cfg_q.source_alignment_log2 <= cfg_i.data.wdata[2:0];
        default: ; // unused indexes are dropped
      endcase
    end
  end

  // front: position tracking, padding and width clipping
  pxe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_data_i  (in_i.data),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_in)
  );

  pxe_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // back: palette store and per-pixel lookup into the output register
  pxe_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_head),
    .job_pop_o   (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

/* rtl/pxe_checker.sv */
// ----------------------------------------------------------------------------
// pxe_checker
// port-level checks of the pixel expander, bound to the top level
// ----------------------------------------------------------------------------
module pxe_checker
  import pxe_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  logic seen_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else if (in_valid_i && in_ready_i) begin
      seen_in_q <= 1'b1;
    end
  end

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  // the image's final pixel closes its byte
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.end_of_image |-> out_data_i.last_of_byte)
    else $error("end of image without last of byte");

  // a further pixel of the same byte needs a next column
  a_col_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.last_of_byte |-> out_data_i.pixel_column != 12'hFFF)
    else $error("pixel continues past the last column");

  // no pixel without any input word
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_in_q)
    else $error("pixel before any input word");

endmodule

bind palette_index_pixel_expander pxe_checker u_pxe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

/* tb/palette_index_pixel_expander_test.sv */
// ----------------------------------------------------------------------------
// palette_index_pixel_expander_test
// self-checking testbench of the palette index pixel expander
// ----------------------------------------------------------------------------
// Drives palette loads and image bytes into the expander. A model of the
// block in this file expands every accepted word into the pixels it should
// give. Each pixel that leaves the block is checked field by field against
// the oldest one still waiting. Directed tests with a long output hold-off
// come first, then random traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
module palette_index_pixel_expander_test
  import pxe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // cycles the block may still spend on padding words after the last pixel
  localparam int DrainCycles    = 64;
  localparam int HoldOffCycles  = 300;
  localparam int RandomPerSetup = 17;
  localparam int EndWaitLimit   = 20000;

  logic clk_i;
  logic rst_ni;

  pxe_chan_if #(.T(in_t))  in_ch ();
  pxe_chan_if #(.T(out_t)) out_ch ();
  pxe_chan_if #(.T(cfg_t)) cfg_ch ();

  palette_index_pixel_expander dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // model state: register copy, palette copy and the three position counters
  cfg_regs_t   shadow;
  logic [31:0] palette_copy [PaletteEntries];
  logic        entry_loaded [PaletteEntries];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned line_pos;

  // pixels predicted but not yet seen at the output, oldest first
  out_t expected_pixels [$];

  int unsigned source_idle_pct;
  int unsigned sink_stall_pct;
  logic        hold_off;
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned pixels_checked;
  int unsigned reg_writes;

  // clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output side: random stalls, or a forced hold-off while the block fills up
  always @(negedge clk_i) begin
    out_ch.ready = !hold_off && ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t mismatch in %s: expected %0h, actual %0h",
               $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // compare each pixel word against the oldest prediction
  always @(posedge clk_i) begin
    out_t exp_px;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected pixel word: expected none, actual %p", $time, out_ch.data);
        error_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        check_field("pixel_color", exp_px.pixel_color, out_ch.data.pixel_color);
        check_field("pixel_column", 32'(exp_px.pixel_column), 32'(out_ch.data.pixel_column));
        check_field("pixel_row", 32'(exp_px.pixel_row), 32'(out_ch.data.pixel_row));
        check_field("last_of_byte", 32'(exp_px.last_of_byte), 32'(out_ch.data.last_of_byte));
        check_field("end_of_image", 32'(exp_px.end_of_image), 32'(out_ch.data.end_of_image));
        pixels_checked++;
      end
    end
  end

  // expands one accepted word into the pixels it yields and moves the counters
  task automatic expand_word(input in_t w);
    int unsigned bits, wid, hgt, bpp, algn, dbytes, llen, per, idx, k;
    logic [31:0] cmask;
    out_t        px;
    out_t        batch [$];
    if (w.operation == OpLoad) begin
      palette_copy[w.entry_index] = w.entry_color;
      entry_loaded[w.entry_index] = 1'b1;
      return;
    end
    bits = shadow.bits_per_index;
    // illegal index width: byte swallowed, counters untouched
    if (bits != BpiOne && bits != BpiFour && bits != BpiEight) return;
    // clamp sizes the same way the block does
    wid = shadow.image_width;
    if (wid == 0) wid = 1;
    if (wid > WidthLim) wid = WidthLim;
    hgt = shadow.image_height;
    if (hgt == 0) hgt = 1;
    if (hgt > 4096) hgt = 4096;
    bpp = shadow.bytes_per_pixel;
    if (bpp == 0) bpp = 1;
    if (bpp > BppLim) bpp = BppLim;
    cmask = (bpp >= 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * bpp)) - 32'd1;
    algn = (shadow.source_alignment_log2 > 4) ? 4 : shadow.source_alignment_log2;
    dbytes = (wid * bits + 7) >> 3;
    llen = (dbytes + (1 << algn) - 1) & ~((1 << algn) - 1);
    per = 8 / bits;
    // data byte: most significant index first, nothing past the row width
    if (line_pos < dbytes) begin
      for (k = 0; k < per && col_pos < wid; k++) begin
        idx = (w.data_byte >> (8 - bits * (k + 1))) & ((1 << bits) - 1);
        px.pixel_color  = palette_copy[idx] & cmask;
        px.pixel_column = col_pos[11:0];
        px.pixel_row    = shadow.flip_vertical ? 12'(hgt - 1 - row_pos) : 12'(row_pos);
        px.last_of_byte = 1'b0;
        px.end_of_image = (col_pos == wid - 1) && (row_pos == hgt - 1);
        batch.push_back(px);
        col_pos = (col_pos + 1) & 32'h1FFF;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_of_byte = 1'b1;
    foreach (batch[i]) expected_pixels.push_back(batch[i]);
    // end of line: padding done, next row, wrap after the last row
    line_pos = (line_pos + 1) & 32'h1FFF;
    if (line_pos >= llen) begin
      line_pos = 0;
      col_pos  = 0;
      row_pos++;
      if (row_pos >= hgt) row_pos = 0;
    end
  endtask

  function automatic logic [7:0] pick_loaded(input int unsigned lim);
    int unsigned tries;
    logic [7:0]  cand;
    for (tries = 0; tries < 16; tries++) begin
      cand = 8'($urandom_range(lim));
      if (entry_loaded[cand]) return cand;
    end
    return 8'd0;
  endfunction

  // unloaded palette entries are undefined, so never let a pixel read one
  function automatic logic [7:0] safe_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    case (shadow.bits_per_index)
      BpiFour: begin
        if (!entry_loaded[r[7:4]]) r[7:4] = 4'(pick_loaded(15));
        if (!entry_loaded[r[3:0]]) r[3:0] = 4'(pick_loaded(15));
      end
      BpiEight: begin
        if (!entry_loaded[r]) r = pick_loaded(255);
      end
      default: ;
    endcase
    return r;
  endfunction

  // one input word: optional idle gap, then hold valid until accepted
  task automatic send_word(input in_t w);
    int unsigned gap;
    if (w.operation == OpPixel) w.data_byte = safe_byte(w.data_byte);
    gap = 0;
    while (gap < 20 && $urandom_range(99) < source_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.data  = w;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    expand_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_load(input logic [7:0] entry, input logic [31:0] color);
    in_t w;
    w.operation   = OpLoad;
    w.entry_index = entry;
    w.entry_color = color;
    w.data_byte   = 8'($urandom());
    send_word(w);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_t w;
    w.operation   = OpPixel;
    w.entry_index = 8'($urandom());
    w.entry_color = $urandom();
    w.data_byte   = b;
    send_word(w);
  endtask

  // register write; bits above the field carry random junk
  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    logic [15:0] fmask, wd;
    case (idx)
      CfgBitsPerIndex:                 fmask = 16'h000F;
      CfgImageWidth, CfgImageHeight:   fmask = 16'h1FFF;
      CfgFlipVertical:                 fmask = 16'h0001;
      default:                         fmask = 16'h0007;
    endcase
    wd = (16'($urandom()) & ~fmask) | (val[15:0] & fmask);
    cfg_ch.data.reg_index = idx;
    cfg_ch.data.wdata     = wd;
    cfg_ch.valid          = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CfgBitsPerIndex:    shadow.bits_per_index        = wd[3:0];
      CfgBytesPerPixel:   shadow.bytes_per_pixel       = wd[2:0];
      CfgImageWidth:      shadow.image_width           = wd[12:0];
      CfgImageHeight:     shadow.image_height          = wd[12:0];
      CfgFlipVertical:    shadow.flip_vertical         = wd[0];
      CfgSourceAlignLog2: shadow.source_alignment_log2 = wd[2:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic setup(input int unsigned bpi, input int unsigned bpp, input int unsigned wid,
                       input int unsigned hgt, input int unsigned flip,
                       input int unsigned algn);
    write_reg(CfgBitsPerIndex, bpi);
    write_reg(CfgBytesPerPixel, bpp);
    write_reg(CfgImageWidth, wid);
    write_reg(CfgImageHeight, hgt);
    write_reg(CfgFlipVertical, flip);
    write_reg(CfgSourceAlignLog2, algn);
  endtask

  // block idle: every pixel out, and time for trailing padding words
  task automatic settle();
    in_ch.valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // reset defaults: 8-bit indices, one pixel images
  task automatic test_palette_defaults();
    send_load(8'h00, 32'hFFFF_FFFF);
    send_load(8'h01, 32'h0000_0000);
    send_load(8'hFF, 32'h5A3C_C3A5);
    send_load(8'h0F, 32'h1234_5678);
    send_load(8'h80, 32'h8421_7BDE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
  endtask

  // 1-bit indices, mirrored rows, two data bytes padded to four,
  // last data byte of each row loses its pixels past the width
  task automatic test_one_bit_rows();
    settle();
    setup(1, 4, 10, 2, 1, 2);
    send_byte(8'hA5);
    send_byte(8'hC0);
    send_byte(8'h3C);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h81);
  endtask

  // 4-bit indices, 16-bit colour, odd width drops the low nibble
  task automatic test_four_bit_rows();
    settle();
    setup(4, 2, 3, 1, 0, 0);
    send_byte(8'h0F);
    send_byte(8'h1F);
  endtask

  // index widths other than 1, 4, 8: bytes eaten silently
  task automatic test_bad_index_width();
    settle();
    write_reg(CfgBitsPerIndex, 2);
    send_byte(8'hFF);
    settle();
    write_reg(CfgBitsPerIndex, 0);
    send_byte(8'h00);
    settle();
    write_reg(CfgBitsPerIndex, 15);
    send_byte(8'hA5);
  endtask

  // zero and oversize width, height, colour bytes and alignment
  task automatic test_size_limits();
    settle();
    setup(8, 0, 0, 0, 1, 7);
    send_byte(8'hFF);
    settle();
    setup(8, 7, 8191, 8191, 1, 4);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  // shrink width and height while mid-row: column past width, mirrored
  // row wrapping below zero
  task automatic test_reconfig_mid_image();
    settle();
    setup(8, 3, 6, 4, 0, 0);
    send_byte(8'h0F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h00);
    settle();
    write_reg(CfgImageWidth, 2);
    send_byte(8'h01);
    settle();
    write_reg(CfgImageHeight, 1);
    write_reg(CfgFlipVertical, 1);
    send_byte(8'h00);
    send_byte(8'h01);
  endtask

  // output held off for a long stretch while 8-pixel bytes keep coming
  task automatic test_backpressure();
    int unsigned n;
    settle();
    source_idle_pct = 0;
    sink_stall_pct  = 0;
    setup(1, 4, 40, 3, 0, 0);
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (n = 0; n < 20; n++) send_byte(8'($urandom()));
  endtask

  // random register set, mostly legal small images, now and then extremes
  task automatic random_setup();
    int unsigned bpi, wid, hgt, algn;
    case ($urandom_range(9))
      0, 1, 2: bpi = BpiOne;
      3, 4, 5: bpi = BpiFour;
      6, 7, 8: bpi = BpiEight;
      default: begin
        do bpi = $urandom_range(15); while (bpi == BpiOne || bpi == BpiFour || bpi == BpiEight);
      end
    endcase
    case ($urandom_range(11))
      0:       wid = 0;
      1:       wid = 4096;
      2:       wid = $urandom_range(8191);
      default: wid = $urandom_range(24, 1);
    endcase
    case ($urandom_range(11))
      0:       hgt = 0;
      1:       hgt = 8191;
      default: hgt = $urandom_range(5, 1);
    endcase
    algn = ($urandom_range(5) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
    setup(bpi, $urandom_range(7), wid, hgt, $urandom_range(1), algn);
  endtask

  // random words, a few loads among image bytes, three settings per phase
  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct);
    in_t w;
    source_idle_pct = src_pct;
    sink_stall_pct  = snk_pct;
    repeat (3) begin
      settle();
      random_setup();
      repeat (RandomPerSetup) begin
        w.operation   = ($urandom_range(99) < 15) ? OpLoad : OpPixel;
        w.entry_index = 8'($urandom_range(255));
        w.entry_color = $urandom();
        w.data_byte   = 8'($urandom_range(255));
        send_word(w);
      end
    end
  endtask

  initial begin
    int unsigned spin;
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    hold_off     = 1'b0;
    source_idle_pct = 0;
    sink_stall_pct  = 0;
    error_count     = 0;
    words_sent      = 0;
    pixels_checked  = 0;
    reg_writes      = 0;
    col_pos  = 0;
    row_pos  = 0;
    line_pos = 0;
    foreach (entry_loaded[i]) begin
      entry_loaded[i] = 1'b0;
      palette_copy[i] = '0;
    end
    // register reset values
    shadow.bits_per_index        = BpiEight;
    shadow.bytes_per_pixel       = 3'd3;
    shadow.image_width           = 13'd1;
    shadow.image_height          = 13'd1;
    shadow.flip_vertical         = 1'b0;
    shadow.source_alignment_log2 = 3'd0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_palette_defaults();
    test_one_bit_rows();
    test_four_bit_rows();
    test_bad_index_width();
    test_size_limits();
    test_reconfig_mid_image();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(65, 0);
    test_random_traffic(0, 65);
    test_random_traffic(31, 31);

    // drain, bounded, then leave the block time to finish padding words
    in_ch.valid = 1'b0;
    for (spin = 0; spin < EndWaitLimit && expected_pixels.size() != 0; spin++)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (expected_pixels.size() != 0) begin
      $display("%0t %0d expected pixels never arrived", $time, expected_pixels.size());
      error_count += expected_pixels.size();
    end

    $display("covered %0d input words, %0d pixels checked, %0d register writes",
             words_sent, pixels_checked, reg_writes);
    $display("1/4/8-bit and illegal index widths, padding, flip, size clamps, "
             , "mid-image changes, output hold-off");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
